// File: hdl/dss_pkg.sv
// dss_pkg: shared constants, types and register codes of the diamond stencil smoother.
// Used by every module of the block; depends on nothing.
package dss_pkg;

   localparam int SAMPLE_BITS   = 16;
   localparam int MAX_COLS      = 256;
   localparam int COL_BITS      = $clog2(MAX_COLS);
   localparam int ROW_BITS      = 16;
   localparam int OUT_COL_BITS  = 8;
   localparam int CFG_COL_BITS  = 9;

   // line store: one word per column, four row slots per word
   localparam int SLOTS         = 4;
   localparam int SLOT_BITS     = $clog2(SLOTS);
   localparam int WIN_TAPS      = 5;
   localparam int CTR_TAP       = 2;
   localparam int HEAD_COLS     = 3;
   localparam int HEAD_BITS     = $clog2(HEAD_COLS);
   localparam int PREFETCH      = 3;
   localparam int BORDER        = 2;

   // arithmetic
   localparam int PART_BITS     = SAMPLE_BITS + 2;
   localparam int SUM_BITS      = SAMPLE_BITS + 8;
   localparam int ROUND_SHIFT   = 6;
   localparam int ROUND_HALF    = 32;

   // result queue
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS     = QPTR_BITS + 1;
   localparam int PUSH_BITS     = 2;
   localparam int READY_LIMIT   = QUEUE_DEPTH - 2;

   // stream and register port
   localparam int REQ_DATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8;
   localparam int RSP_RAW_BITS  = SAMPLE_BITS + ROW_BITS + OUT_COL_BITS;
   localparam int RSP_DATA_BITS = ((RSP_RAW_BITS + 7) / 8) * 8;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_INDEX_LSB = 2;
   localparam int CSR_DATA_BITS = 32;
   localparam int ROWS_RESET    = 64;
   localparam int COLS_RESET    = 64;

   typedef enum logic {
      REG_PLANE_ROWS = 1'b0,
      REG_PLANE_COLS = 1'b1
   } reg_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [SLOTS-1:0][SAMPLE_BITS-1:0] word_type;
   typedef word_type [WIN_TAPS-1:0] window_type;

   typedef struct packed {
      logic                 wr_en;
      logic                 row_end;
      logic [SLOT_BITS-1:0] slot;
      logic [COL_BITS-1:0]  col;
      logic [COL_BITS-1:0]  next_col;
   } win_ctl_type;

   typedef struct packed {
      logic                valid;
      logic                out_en;
      logic                interior;
      logic                copy_en;
      logic                done;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col;
   } step_type;

   typedef struct packed {
      sample_type              sample;
      logic [ROW_BITS-1:0]     row;
      logic [OUT_COL_BITS-1:0] col;
      logic                    done;
   } result_type;

   typedef struct packed {
      logic [PUSH_BITS-1:0] n;
      result_type           first;
      result_type           second;
   } push_type;

endpackage

// File: hdl/diamond_stencil_smoother_unit.sv
// diamond_stencil_smoother_unit: top level, register port, raster position and step control.
// Depends on dss_pkg, dss_window, dss_stencil, dss_out_queue.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_tvalid/req_tready  | tdata: sample_in
//   rsp     | out       | rsp_tvalid/rsp_tready  | tdata: sample_out,out_row,out_col; tlast
//   csr     | in        | csr_psel/csr_penable   | plane_rows @0x0, plane_cols @0x4
//
// One item per cycle while rsp_tready holds and each item gives at most one result; in the
// last two rows of a plane each item from row 2 on gives two, and the single result port sets
// the pace at one result a cycle at most. Results are registered in the sum stage, then queued.
// Line store is one 256-word memory, one read and one write per cycle; column words are
// prefetched three columns ahead. Reset clears position, queue and registers (64 x 64);
// the line store is not cleared. req_tready drops while queue plus sum stage hold > 2 results.
module diamond_stencil_smoother_unit (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [dss_pkg::REQ_DATA_BITS-1:0]   req_tdata,   // [15:0] sample_in
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [dss_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,   // [15:0] sample_out, [31:16] out_row,
                                                            // [39:32] out_col
   output logic                                rsp_tlast,   // plane_done
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dss_pkg::CSR_ADDR_BITS-1:0]   csr_paddr,
   input  logic [dss_pkg::CSR_DATA_BITS-1:0]   csr_pwdata,
   output logic [dss_pkg::CSR_DATA_BITS-1:0]   csr_prdata,
   output logic                                csr_pready
);

   logic [dss_pkg::ROW_BITS-1:0]     plane_rows_ff;
   logic [dss_pkg::CFG_COL_BITS-1:0] plane_cols_ff;
   logic [dss_pkg::ROW_BITS-1:0]     row_pos_ff, row_pos_in;
   logic [dss_pkg::COL_BITS-1:0]     col_pos_ff, col_pos_in;
   logic [dss_pkg::ROW_BITS-1:0]     last_row;
   logic [dss_pkg::COL_BITS-1:0]     last_col;
   logic                             cfg_write;
   logic                             accept;
   logic                             row_end;
   dss_pkg::reg_index_type           reg_sel;
   dss_pkg::sample_type              sample;
   dss_pkg::step_type                step;
   dss_pkg::win_ctl_type             win_ctl;
   dss_pkg::window_type              win;
   dss_pkg::push_type                push;
   dss_pkg::result_type              out_item;
   logic [dss_pkg::QCNT_BITS-1:0]    queue_count;

   // register port
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel    = dss_pkg::reg_index_type'(
                          csr_paddr[dss_pkg::CSR_ADDR_BITS-1:dss_pkg::CSR_INDEX_LSB]);

   always_comb begin
      unique case (reg_sel)
         dss_pkg::REG_PLANE_ROWS: csr_prdata = dss_pkg::CSR_DATA_BITS'(plane_rows_ff);
         dss_pkg::REG_PLANE_COLS: csr_prdata = dss_pkg::CSR_DATA_BITS'(plane_cols_ff);
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_rows_ff <= dss_pkg::ROW_BITS'(dss_pkg::ROWS_RESET);
         plane_cols_ff <= dss_pkg::CFG_COL_BITS'(dss_pkg::COLS_RESET);
      end else if (cfg_write) begin
         unique case (reg_sel)
            dss_pkg::REG_PLANE_ROWS:
               plane_rows_ff <= csr_pwdata[dss_pkg::ROW_BITS-1:0];
            dss_pkg::REG_PLANE_COLS:
               plane_cols_ff <= csr_pwdata[dss_pkg::CFG_COL_BITS-1:0];
         endcase
      end
   end

   // zero acts as one; columns clamp to the line store width
   always_comb begin
      last_row = (plane_rows_ff == '0) ? '0 : plane_rows_ff - dss_pkg::ROW_BITS'(1);
      if (plane_cols_ff == '0) begin
         last_col = '0;
      end else if (plane_cols_ff > dss_pkg::CFG_COL_BITS'(dss_pkg::MAX_COLS)) begin
         last_col = dss_pkg::COL_BITS'(dss_pkg::MAX_COLS - 1);
      end else begin
         last_col = dss_pkg::COL_BITS'(plane_cols_ff - dss_pkg::CFG_COL_BITS'(1));
      end
   end

   // raster position and per-item control
   assign sample  = req_tdata[dss_pkg::SAMPLE_BITS-1:0];
   assign accept  = req_tvalid && req_tready;
   assign row_end = (col_pos_ff == last_col);

   assign req_tready = ({1'b0, queue_count} + (dss_pkg::QCNT_BITS+1)'(push.n)) <=
                       (dss_pkg::QCNT_BITS+1)'(dss_pkg::READY_LIMIT);

   always_comb begin
      step.valid    = accept;
      step.out_en   = row_pos_ff >= dss_pkg::ROW_BITS'(dss_pkg::BORDER);
      step.interior = (row_pos_ff >= dss_pkg::ROW_BITS'(2 * dss_pkg::BORDER)) &&
                      (col_pos_ff >= dss_pkg::COL_BITS'(dss_pkg::BORDER)) &&
                      (({1'b0, col_pos_ff} + (dss_pkg::COL_BITS+1)'(dss_pkg::BORDER)) <=
                       {1'b0, last_col});
      // copy out the raw sample in the last two rows
      step.copy_en  = ({1'b0, row_pos_ff} + (dss_pkg::ROW_BITS+1)'(1)) >= {1'b0, last_row};
      step.done     = (row_pos_ff == last_row) && row_end;
      step.row      = row_pos_ff;
      step.col      = col_pos_ff;
   end

   always_comb begin
      row_pos_in = row_pos_ff;
      col_pos_in = col_pos_ff;
      if (cfg_write) begin
         row_pos_in = '0;
         col_pos_in = '0;
      end else if (accept) begin
         if (row_end) begin
            col_pos_in = '0;
            row_pos_in = (row_pos_ff == last_row) ? '0 : row_pos_ff + dss_pkg::ROW_BITS'(1);
         end else begin
            col_pos_in = col_pos_ff + dss_pkg::COL_BITS'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_pos_ff <= '0;
         col_pos_ff <= '0;
      end else begin
         row_pos_ff <= row_pos_in;
         col_pos_ff <= col_pos_in;
      end
   end

   always_comb begin
      win_ctl.wr_en    = accept;
      win_ctl.row_end  = row_end;
      win_ctl.slot     = row_pos_ff[dss_pkg::SLOT_BITS-1:0];
      win_ctl.col      = col_pos_ff;
      win_ctl.next_col = col_pos_in;
   end

   dss_window u_window (
      .clock  (clock),
      .reset  (reset),
      .ctl    (win_ctl),
      .sample (sample),
      .win    (win)
   );

   dss_stencil u_stencil (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .win    (win),
      .sample (sample),
      .push   (push)
   );

   dss_out_queue u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_item  (out_item),
      .count     (queue_count)
   );

   assign rsp_tdata = dss_pkg::RSP_DATA_BITS'({out_item.col, out_item.row, out_item.sample});
   assign rsp_tlast = out_item.done;

   a_col_in_row: assert property (@(posedge clock) disable iff (reset)
      col_pos_ff <= last_col)
      else $error("column position past end of row");

   a_row_in_plane: assert property (@(posedge clock) disable iff (reset)
      row_pos_ff <= last_row)
      else $error("row position past end of plane");

   a_wrap_restarts_row: assert property (@(posedge clock) disable iff (reset)
      (accept && row_end && !cfg_write) |=> (col_pos_ff == '0))
      else $error("row wrap did not return to column zero");

endmodule

// File: hdl/dss_window.sv
// dss_window: column-word line store (read-modify-write) and the 5-column stencil window.
// Depends on dss_pkg.
module dss_window (
   input  logic                 clock,
   input  logic                 reset,
   input  dss_pkg::win_ctl_type ctl,
   input  dss_pkg::sample_type  sample,
   output dss_pkg::window_type  win
);

   dss_pkg::word_type   mem [dss_pkg::MAX_COLS];
   dss_pkg::word_type   head_ff [dss_pkg::HEAD_COLS];
   dss_pkg::word_type   head_in [dss_pkg::HEAD_COLS];
   dss_pkg::window_type win_ff;
   dss_pkg::window_type win_in;
   dss_pkg::word_type   rd_data_ff;
   dss_pkg::word_type   wr_data_ff;
   dss_pkg::word_type   wr_word;
   dss_pkg::word_type   fwd_word;
   logic [dss_pkg::COL_BITS-1:0] rd_addr;
   logic [dss_pkg::COL_BITS-1:0] rd_addr_ff;
   logic [dss_pkg::COL_BITS-1:0] wr_addr_ff;
   logic                         wr_en_ff;

   // look three columns ahead of the next item
   assign rd_addr = ctl.next_col + dss_pkg::COL_BITS'(dss_pkg::PREFETCH);

   // a write in the cycle of the read wins over the stale array data
   assign fwd_word = (wr_en_ff && (wr_addr_ff == rd_addr_ff)) ? wr_data_ff : rd_data_ff;

   always_comb begin
      wr_word = win_ff[dss_pkg::CTR_TAP];
      wr_word[ctl.slot] = sample;
   end

   // first columns of the row in flight, reloaded into the window at row wrap
   always_comb begin
      head_in = head_ff;
      if (ctl.wr_en && (ctl.col < dss_pkg::COL_BITS'(dss_pkg::HEAD_COLS))) begin
         head_in[ctl.col[dss_pkg::HEAD_BITS-1:0]] = wr_word;
      end
   end

   always_comb begin
      win_in = win_ff;
      if (ctl.wr_en) begin
         if (ctl.row_end) begin
            for (int j = 0; j < dss_pkg::HEAD_COLS; j++) begin
               win_in[dss_pkg::CTR_TAP + j] = head_in[j];
            end
         end else begin
            for (int k = 0; k < dss_pkg::WIN_TAPS - 1; k++) begin
               win_in[k] = win_ff[k + 1];
            end
            win_in[dss_pkg::WIN_TAPS-1] = fwd_word;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.col] <= wr_word;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      rd_addr_ff <= rd_addr;
      wr_addr_ff <= ctl.col;
      wr_data_ff <= wr_word;
      win_ff     <= win_in;
      head_ff    <= head_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_en_ff <= 1'b0;
      end else begin
         wr_en_ff <= ctl.wr_en;
      end
   end

   assign win = win_ff;

endmodule

// File: hdl/dss_stencil.sv
// dss_stencil: two-stage weighted sum (partial sums, then total and rounding) and result build.
// Depends on dss_pkg.
module dss_stencil (
   input  logic                clock,
   input  logic                reset,
   input  dss_pkg::step_type   step,
   input  dss_pkg::window_type win,
   input  dss_pkg::sample_type sample,
   output dss_pkg::push_type   push
);

   function automatic logic signed [dss_pkg::PART_BITS-1:0] add4(
      input dss_pkg::sample_type a,
      input dss_pkg::sample_type b,
      input dss_pkg::sample_type c,
      input dss_pkg::sample_type d
   );
      return dss_pkg::PART_BITS'(a) + dss_pkg::PART_BITS'(b) +
             dss_pkg::PART_BITS'(c) + dss_pkg::PART_BITS'(d);
   endfunction

   // slots of rows r-1, r-2, r-3 and r-4 (same slot as r)
   logic [dss_pkg::SLOT_BITS-1:0] slot_m1, slot_m2, slot_m3, slot_m4;
   dss_pkg::sample_type ctr;
   logic signed [dss_pkg::PART_BITS-1:0] ax_sum, dg_sum, far_sum;
   logic [dss_pkg::PUSH_BITS-1:0] n_in;

   logic [dss_pkg::PUSH_BITS-1:0] n_ff;
   logic                          out_en_ff;
   logic                          interior_ff;
   logic                          done_ff;
   logic [dss_pkg::ROW_BITS-1:0]  row_ff;
   logic [dss_pkg::COL_BITS-1:0]  col_ff;
   dss_pkg::sample_type           ctr_ff;
   dss_pkg::sample_type           x_ff;
   logic signed [dss_pkg::PART_BITS-1:0] ax_ff, dg_ff, far_ff;

   logic signed [dss_pkg::SUM_BITS-1:0] c_ext;
   logic signed [dss_pkg::SUM_BITS-1:0] total;
   dss_pkg::sample_type  smooth;
   dss_pkg::result_type  res_out;
   dss_pkg::result_type  res_copy;

   always_comb begin
      slot_m4 = step.row[dss_pkg::SLOT_BITS-1:0];
      slot_m1 = slot_m4 - dss_pkg::SLOT_BITS'(1);
      slot_m2 = slot_m4 - dss_pkg::SLOT_BITS'(2);
      slot_m3 = slot_m4 - dss_pkg::SLOT_BITS'(3);
      ctr     = win[2][slot_m2];
      ax_sum  = add4(win[1][slot_m2], win[3][slot_m2], win[2][slot_m1], win[2][slot_m3]);
      dg_sum  = add4(win[1][slot_m1], win[3][slot_m1], win[1][slot_m3], win[3][slot_m3]);
      far_sum = add4(win[0][slot_m2], win[4][slot_m2], win[2][slot_m4], sample);
      n_in    = '0;
      if (step.valid) begin
         n_in = dss_pkg::PUSH_BITS'(step.out_en) + dss_pkg::PUSH_BITS'(step.copy_en);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         n_ff <= '0;
      end else begin
         n_ff <= n_in;
      end
   end

   always_ff @(posedge clock) begin
      out_en_ff   <= step.out_en;
      interior_ff <= step.interior;
      done_ff     <= step.done;
      row_ff      <= step.row;
      col_ff      <= step.col;
      ctr_ff      <= ctr;
      x_ff        <= sample;
      ax_ff       <= ax_sum;
      dg_ff       <= dg_sum;
      far_ff      <= far_sum;
   end

   // 36*ctr + 4*axial + 2*diagonal + far + half, then floor by 64
   always_comb begin
      c_ext  = dss_pkg::SUM_BITS'(ctr_ff);
      total  = (c_ext <<< 5) + (c_ext <<< 2) +
               (dss_pkg::SUM_BITS'(ax_ff) <<< 2) + (dss_pkg::SUM_BITS'(dg_ff) <<< 1) +
               dss_pkg::SUM_BITS'(far_ff) + dss_pkg::SUM_BITS'(dss_pkg::ROUND_HALF);
      smooth = total[dss_pkg::ROUND_SHIFT +: dss_pkg::SAMPLE_BITS];

      res_out.sample = interior_ff ? smooth : ctr_ff;
      res_out.row    = row_ff - dss_pkg::ROW_BITS'(dss_pkg::BORDER);
      res_out.col    = dss_pkg::OUT_COL_BITS'(col_ff);
      res_out.done   = 1'b0;

      res_copy.sample = x_ff;
      res_copy.row    = row_ff;
      res_copy.col    = dss_pkg::OUT_COL_BITS'(col_ff);
      res_copy.done   = done_ff;

      push.n      = n_ff;
      push.first  = out_en_ff ? res_out : res_copy;
      push.second = res_copy;
   end

endmodule

// File: hdl/dss_out_queue.sv
// dss_out_queue: four-entry result queue taking up to two items per cycle, one out per cycle.
// Depends on dss_pkg.
module dss_out_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  dss_pkg::push_type              push,
   input  logic                           out_ready,
   output logic                           out_valid,
   output dss_pkg::result_type            out_item,
   output logic [dss_pkg::QCNT_BITS-1:0]  count
);

   dss_pkg::result_type slots_ff [dss_pkg::QUEUE_DEPTH];
   logic [dss_pkg::QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in, wr_ptr_nx;
   logic [dss_pkg::QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [dss_pkg::QCNT_BITS-1:0] count_ff, count_in;
   logic                          pop;

   assign pop       = (count_ff != '0) && out_ready;
   assign wr_ptr_nx = wr_ptr_ff + dss_pkg::QPTR_BITS'(1);

   always_comb begin
      wr_ptr_in = wr_ptr_ff + dss_pkg::QPTR_BITS'(push.n);
      rd_ptr_in = rd_ptr_ff + dss_pkg::QPTR_BITS'(pop);
      count_in  = count_ff + dss_pkg::QCNT_BITS'(push.n) - dss_pkg::QCNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (push.n != '0) begin
         slots_ff[wr_ptr_ff] <= push.first;
      end
      if (push.n == dss_pkg::PUSH_BITS'(2)) begin
         slots_ff[wr_ptr_nx] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   assign out_valid = (count_ff != '0);
   assign out_item  = slots_ff[rd_ptr_ff];
   assign count     = count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= dss_pkg::QCNT_BITS'(dss_pkg::QUEUE_DEPTH))
      else $error("result queue count beyond depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + (dss_pkg::QCNT_BITS+1)'(push.n)) <=
      ((dss_pkg::QCNT_BITS+1)'(dss_pkg::QUEUE_DEPTH) + (dss_pkg::QCNT_BITS+1)'(pop)))
      else $error("result queue overflow");

   a_two_slot_push: assert property (@(posedge clock) disable iff (reset)
      push.n != dss_pkg::PUSH_BITS'(3))
      else $error("more than two results from one item");

endmodule

// File: verif/tb_top.sv
// tb_top: self-checking bench for diamond_stencil_smoother_unit, driven over its item streams
// and register port. Needs dss_pkg and the unit; predicts every result and checks it in order.
`timescale 1ns / 100ps

module tb_top;
   import dss_pkg::*;

   localparam sample_type SAMPLE_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
   localparam sample_type SAMPLE_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
   localparam int         TARGET_ITEMS = 900;
   localparam int         SETTLE_CYCLES = 8;
   localparam int         STALL_CYCLES  = 300;

   typedef enum int {
      FILL_RANDOM, FILL_EXTREME, FILL_NEAR_ZERO, FILL_MAX, FILL_MIN, FILL_MIXED
   } fill_kind;

   // Predicts the smoothed raster and holds the results still owed by the unit.
   class smoother_board;
      sample_type              line_mem [SLOTS*MAX_COLS];
      int unsigned             row_pos;
      int unsigned             col_pos;
      logic [ROW_BITS-1:0]     plane_rows;
      logic [CFG_COL_BITS-1:0] plane_cols;
      result_type              owed [$];
      int                      errors;
      int                      checked;

      function new();
         plane_rows = ROWS_RESET;
         plane_cols = COLS_RESET;
         row_pos    = 0;
         col_pos    = 0;
         errors     = 0;
         checked    = 0;
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= 10) begin
            $display("MISMATCH: %0s", msg);
         end
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
         if (idx == REG_PLANE_ROWS) begin
            plane_rows = value[ROW_BITS-1:0];
         end else begin
            plane_cols = value[CFG_COL_BITS-1:0];
         end
         // any write restarts the plane at (0,0)
         row_pos = 0;
         col_pos = 0;
      endfunction

      function longint tap(int unsigned row, int unsigned col);
         return line_mem[(row % SLOTS) * MAX_COLS + (col % MAX_COLS)];
      endfunction

      function void take_sample(sample_type x);
         int unsigned rows;
         int unsigned cols;
         int unsigned r;
         int unsigned c;
         int unsigned o;
         longint      acc;
         result_type  res;
         rows = (plane_rows == 0) ? 1 : plane_rows;
         cols = (plane_cols == 0) ? 1 : ((plane_cols > MAX_COLS) ? MAX_COLS : plane_cols);
         r = row_pos;
         c = col_pos;
         if (c >= cols) begin
            c = cols - 1;
         end
         if (r >= 2) begin
            o = r - 2;
            if (o >= 2 && o + 3 <= rows && c >= 2 && c + 3 <= cols) begin
               acc = 36 * tap(o, c)
                   + 4 * (tap(o-1, c) + tap(o+1, c) + tap(o, c-1) + tap(o, c+1))
                   + 2 * (tap(o-1, c-1) + tap(o-1, c+1) + tap(o+1, c-1) + tap(o+1, c+1))
                   + tap(o-2, c) + longint'(x) + tap(o, c-2) + tap(o, c+2);
               acc = (acc + ROUND_HALF) >>> ROUND_SHIFT;   // floor, so round half up
               res.sample = sample_type'(acc);
            end else begin
               res.sample = sample_type'(tap(o, c));
            end
            res.row  = o[ROW_BITS-1:0];
            res.col  = c[OUT_COL_BITS-1:0];
            res.done = 1'b0;
            owed.push_back(res);
         end
         line_mem[(r % SLOTS) * MAX_COLS + c] = x;
         // last two rows are also copied straight out
         if (r + 2 >= rows) begin
            res.sample = x;
            res.row    = r[ROW_BITS-1:0];
            res.col    = c[OUT_COL_BITS-1:0];
            res.done   = (r + 1 >= rows && c + 1 >= cols);
            owed.push_back(res);
         end
         if (c + 1 >= cols) begin
            col_pos = 0;
            row_pos = (r + 1 >= rows) ? 0 : r + 1;
         end else begin
            col_pos = c + 1;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         if (owed.size() == 0) begin
            flag($sformatf("unexpected result sample %0d row %0d col %0d last %0b",
                           $signed(got.sample), got.row, got.col, got.done));
            return;
         end
         want = owed.pop_front();
         checked++;
         if (got.sample !== want.sample || got.row !== want.row ||
             got.col !== want.col || got.done !== want.done) begin
            flag($sformatf("expected sample %0d row %0d col %0d last %0b, got %0d %0d %0d %0b",
                           $signed(want.sample), want.row, want.col, want.done,
                           $signed(got.sample), got.row, got.col, got.done));
         end
      endfunction
   endclass

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata   = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tlast;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   smoother_board board = new();

   int sent       = 0;
   int wide_items = 0;
   int writes     = 0;
   int shapes     = 0;
   int send_idle  = 0;
   int recv_idle  = 0;
   bit hold_req   = 1'b0;
   int hold_left  = 0;

   diamond_stencil_smoother_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic sample_type pick_sample(fill_kind fill);
      case (fill)
         FILL_RANDOM:    return sample_type'($urandom);
         FILL_EXTREME:   return $urandom_range(1) ? SAMPLE_MAX : SAMPLE_MIN;
         FILL_NEAR_ZERO: return sample_type'(int'($urandom_range(6)) - 3);
         FILL_MAX:       return SAMPLE_MAX;
         FILL_MIN:       return SAMPLE_MIN;
         default: begin
            case ($urandom_range(7))
               0:       return SAMPLE_MAX;
               1:       return SAMPLE_MIN;
               default: return sample_type'($urandom);
            endcase
         end
      endcase
   endfunction

   task automatic send_sample(sample_type s);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      do @(posedge clock); while (!req_tready);
      board.take_sample(s);
      sent++;
   endtask

   // stop sending and wait until every owed result is back, plus the pipeline tail
   task automatic drain();
      req_tvalid <= 1'b0;
      while (board.owed.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic program_reg(reg_index_type idx, logic [CSR_DATA_BITS-1:0] value);
      logic [CSR_DATA_BITS-1:0] back;
      logic [CSR_DATA_BITS-1:0] mask;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= CSR_ADDR_BITS'(int'(idx) << CSR_INDEX_LSB);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      board.write_reg(idx, value);
      writes++;
      // read it back
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      back = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      mask = (idx == REG_PLANE_ROWS) ? CSR_DATA_BITS'((1 << ROW_BITS) - 1)
                                     : CSR_DATA_BITS'((1 << CFG_COL_BITS) - 1);
      if ((back & mask) !== (value & mask)) begin
         board.flag($sformatf("register %0d read %0d, written %0d", idx, back & mask,
                              value & mask));
      end
   endtask

   task automatic run_phase(int rows, int cols, int count, fill_kind fill, bit pause_mid);
      drain();
      if (rows != board.plane_rows || $urandom_range(3) != 0) begin
         program_reg(REG_PLANE_ROWS, rows);
      end
      if (cols != board.plane_cols || $urandom_range(3) != 0) begin
         program_reg(REG_PLANE_COLS, cols);
      end
      shapes++;
      for (int i = 0; i < count; i++) begin
         if (pause_mid && i == count / 2) begin
            drain();
         end
         send_sample(pick_sample(fill));
      end
   endtask

   // result side: check accepted items, drive tready with random and forced stalls
   initial begin
      result_type got;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            got.sample = rsp_tdata[SAMPLE_BITS-1:0];
            got.row    = rsp_tdata[SAMPLE_BITS +: ROW_BITS];
            got.col    = rsp_tdata[SAMPLE_BITS+ROW_BITS +: OUT_COL_BITS];
            got.done   = rsp_tlast;
            board.check_result(got);
         end
         if (hold_req) begin
            hold_left = STALL_CYCLES;
            hold_req  = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_idle);
         end
      end
   end

   initial begin
      int       steady;
      int       rows;
      int       cols;
      int       count;
      int       size;
      int       start;
      bit       wide_done;
      bit       paused;
      bit       stalled;
      wide_done = 1'b0;
      paused    = 1'b0;
      stalled   = 1'b0;
      send_idle = 31;
      recv_idle = 50;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // single row with the column count left at its reset value
      program_reg(REG_PLANE_ROWS, 1);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample('0);
      send_sample(sample_type'(16'h5555));
      send_sample(sample_type'(-1));
      // zero rows and zero columns act as a 1x1 plane
      run_phase(0, 0, 0, FILL_RANDOM, 1'b0);
      send_sample(SAMPLE_MAX);
      send_sample(SAMPLE_MIN);
      send_sample(sample_type'(16'h2AAA));
      // smallest plane with an interior point, checkerboard of extremes
      run_phase(5, 5, 0, FILL_RANDOM, 1'b0);
      for (int i = 0; i < 25; i++) begin
         send_sample(((i / 5 + i % 5) % 2) ? SAMPLE_MAX : SAMPLE_MIN);
      end

      while (sent - wide_items < TARGET_ITEMS) begin
         steady = sent - wide_items;
         if (steady < 300) begin
            send_idle = 31;
            recv_idle = 50;
         end else if (steady < 600) begin
            send_idle = 50;
            recv_idle = 31;
         end else begin
            send_idle = 0;
            recv_idle = 0;
            if (!stalled) begin
               // long output stall while the sender keeps offering items
               hold_req = 1'b1;
               stalled  = 1'b1;
            end
         end
         if (!wide_done && steady >= 300) begin
            // widest row: column count above the limit clamps to MAX_COLS
            start = sent;
            run_phase(5, 511, 5 * MAX_COLS + $urandom_range(3, 20), FILL_MIXED, 1'b0);
            wide_items += sent - start;
            wide_done = 1'b1;
         end else begin
            case ($urandom_range(9))
               0:       rows = 0;
               1:       rows = 65535;
               2:       rows = $urandom_range(1, 4);
               default: rows = $urandom_range(5, 9);
            endcase
            case ($urandom_range(9))
               0:       cols = 0;
               1:       cols = $urandom_range(1, 4);
               default: cols = $urandom_range(5, 12);
            endcase
            size = (rows == 0 ? 1 : rows) * (cols == 0 ? 1 : cols);
            if (rows == 65535) begin
               count = (cols == 0 ? 1 : cols) * $urandom_range(3, 7);
            end else begin
               // often stops mid-plane, so the next write restarts it
               count = size * $urandom_range(1, 2) + $urandom_range(0, size);
            end
            run_phase(rows, cols, count, fill_kind'($urandom_range(5)),
                      !paused && steady >= 450);
            if (steady >= 450) begin
               paused = 1'b1;
            end
         end
      end

      drain();
      repeat (20) @(posedge clock);
      $display("Covered %0d samples and %0d results over %0d plane shapes, %0d register writes,",
               sent, board.checked, shapes, writes);
      $display("including a clamped 256-wide plane, a long output stall and a sender pause.");
      if (board.errors == 0 && board.owed.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule

// File: diamond_stencil_smoother_unit.f
hdl/dss_pkg.sv
hdl/dss_window.sv
hdl/dss_stencil.sv
hdl/dss_out_queue.sv
hdl/diamond_stencil_smoother_unit.sv
verif/tb_top.sv
